>>> design/ema_pkg.sv
package ema_pkg;

  // default parameter values
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int MAX_SAMPLES_DEF = 65536;

  // result field widths
  localparam int MEAN_W  = 17;
  localparam int MSE_W   = 32;
  localparam int RMS_W   = 16;
  localparam int RATIO_W = 32;

  // ratio fraction bits, accumulator ceiling, step counter width
  localparam int FRAC_W      = 16;
  localparam int ACC_LIMIT_W = 64;
  localparam int STEP_W      = 7;

  // mean magnitude clamp
  localparam int                    MEAN_MAG_W   = 16;
  localparam logic [MEAN_MAG_W-1:0] MEAN_MAG_MAX = '1;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_DIFF,
    ST_MUL_TGT,
    ST_ACC_TGT,
    ST_MEAN,
    ST_MEAN_WAIT,
    ST_MSE_WAIT,
    ST_ROOT_WAIT,
    ST_RATIO,
    ST_RATIO_WAIT,
    ST_OUT
  } ema_state_t;

  // shared compare-subtract unit operations
  typedef enum logic {
    CSU_DIV,
    CSU_SQRT
  } csu_mode_t;

  typedef struct packed {
    logic              start;
    csu_mode_t         mode;
    logic [STEP_W-1:0] steps;
  } csu_ctrl_t;

endpackage

>>> design/ema_ifs.sv
interface ema_in_if import ema_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] target_sample;
  logic signed [SAMPLE_BITS-1:0] predicted_sample;
  logic                          last_sample;

  modport source (output valid, target_sample, predicted_sample, last_sample, input ready);
  modport sink   (input valid, target_sample, predicted_sample, last_sample, output ready);
endinterface

interface ema_out_if import ema_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [MEAN_W-1:0] mean_diff;
  logic [MSE_W-1:0]         mean_sq_error;
  logic [RMS_W-1:0]         root_mean_sq;
  logic [RATIO_W-1:0]       energy_ratio;
  logic                     ratio_invalid;
  logic                     overflowed;

  modport source (output valid, mean_diff, mean_sq_error, root_mean_sq, energy_ratio,
                  ratio_invalid, overflowed, input ready);
  modport sink   (input valid, mean_diff, mean_sq_error, root_mean_sq, energy_ratio,
                  ratio_invalid, overflowed, output ready);
endinterface

>>> design/ema_csu.sv
module ema_csu import ema_pkg::*; #(
  parameter int NUM_W = 65,
  parameter int DEN_W = 48
) (
  input  logic             clk,
  input  logic             rst_n,
  input  csu_ctrl_t        ctrl,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  logic [NUM_W-1:0]  acc_r;
  logic [NUM_W-1:0]  acc_nxt;
  logic [DEN_W:0]    rem_r;
  logic [DEN_W:0]    rem_sh;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    rem_sub;
  logic [DEN_W:0]    rem_nxt;
  logic [DEN_W-1:0]  den_r;
  logic [NUM_W-1:0]  quo_r;
  logic [NUM_W-1:0]  quo_nxt;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  csu_mode_t         mode_r;
  logic              ge;

  // one step: divide brings in one numerator bit, root brings in two
  always_comb begin
    if (mode_r == CSU_SQRT) begin
      rem_sh  = {rem_r[DEN_W-2:0], acc_r[NUM_W-1 -: 2]};
      trial   = {quo_r[DEN_W-2:0], 2'b01};
      acc_nxt = acc_r << 2;
    end else begin
      rem_sh  = {rem_r[DEN_W-1:0], acc_r[NUM_W-1]};
      trial   = {1'b0, den_r};
      acc_nxt = acc_r << 1;
    end
    ge      = (rem_sh >= trial);
    rem_sub = rem_sh - trial;
    rem_nxt = ge ? rem_sub : rem_sh;
    quo_nxt = {quo_r[NUM_W-2:0], ge};
  end

  // step counter and completion pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= ctrl.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operand and partial result registers
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      acc_r  <= num;
      rem_r  <= '0;
      quo_r  <= '0;
      den_r  <= den;
      mode_r <= ctrl.mode;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

>>> design/error_metric_accumulator.sv
// Non-final sample: ready drops after each transfer while the sample passes through
// ST_MUL_DIFF, ST_MUL_TGT and ST_ACC_TGT (two squarings through one shared multiplier,
// then the target-energy add). Final sample: the bit-serial divide/root unit computes the
// results, which are loaded into the output register once that register is free. The result
// waits in the output register; the next set streams in.
// Reset: rst_n synchronous, active low; clears sequencer, accumulators and output valid.
module error_metric_accumulator import ema_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input logic       clk,
  input logic       rst_n,
  ema_in_if.sink    in_ch,
  ema_out_if.source out_ch
);

  localparam int CNT_W    = $clog2(MAX_SAMPLES + 1);
  localparam int MAG_W    = SAMPLE_BITS + CNT_W;
  localparam int DIFF_W   = MAG_W + 1;
  localparam int PROD_W   = 2 * SAMPLE_BITS;
  localparam int SQ_RAW_W = 2 * SAMPLE_BITS + CNT_W;
  localparam int SQ_W     = (SQ_RAW_W > ACC_LIMIT_W) ? ACC_LIMIT_W : SQ_RAW_W;
  localparam int TE_RAW_W = 2 * SAMPLE_BITS - 1 + CNT_W;
  localparam int TE_W     = (TE_RAW_W > ACC_LIMIT_W) ? ACC_LIMIT_W : TE_RAW_W;
  localparam int NUM_W    = SQ_W + FRAC_W;
  localparam int DEN_W    = TE_W;

  ema_state_t state_r;
  ema_state_t state_nxt;

  // captured sample
  logic signed [SAMPLE_BITS-1:0] tgt_r;
  logic signed [SAMPLE_BITS-1:0] pred_r;
  logic                          last_r;
  logic                          take_r;

  // accumulators
  logic [CNT_W-1:0]         cnt_r;
  logic signed [DIFF_W-1:0] diff_sum_r;
  logic [SQ_W-1:0]          sq_sum_r;
  logic [TE_W-1:0]          te_r;
  logic                     ovf_r;
  logic [PROD_W-1:0]        prod_r;

  // working results
  logic signed [MEAN_W-1:0] mean_r;
  logic [MSE_W-1:0]         mse_r;
  logic [RMS_W-1:0]         rms_r;
  logic [RATIO_W-1:0]       ratio_r;
  logic                     inv_r;

  // output register
  logic                     out_valid_r;
  logic signed [MEAN_W-1:0] o_mean_r;
  logic [MSE_W-1:0]         o_mse_r;
  logic [RMS_W-1:0]         o_rms_r;
  logic [RATIO_W-1:0]       o_ratio_r;
  logic                     o_inv_r;
  logic                     o_ovf_r;

  logic in_ready_w;
  logic in_xfer;
  logic out_load;

  // shared unit connections
  csu_ctrl_t        csu_ctrl;
  logic [NUM_W-1:0] csu_num;
  logic [DEN_W-1:0] csu_den;
  logic             csu_done;
  logic [NUM_W-1:0] csu_quo;

  // sample datapath
  logic signed [SAMPLE_BITS:0] diff_s;
  logic [SAMPLE_BITS:0]        diff_abs;
  logic [SAMPLE_BITS:0]        tgt_abs;
  logic [SAMPLE_BITS-1:0]      mul_op;
  logic [PROD_W-1:0]           prod_nxt;
  logic [SQ_W:0]               sq_sum_ext;
  logic [SQ_W-1:0]             sq_sum_nxt;
  logic [TE_W:0]               te_ext;
  logic [TE_W-1:0]             te_nxt;

  // finishing datapath
  logic                     sum_neg;
  logic [DIFF_W-1:0]        sum_abs;
  logic [ACC_LIMIT_W-1:0]   mean_abs64;
  logic [MEAN_MAG_W-1:0]    mean_mag;
  logic signed [MEAN_W-1:0] mean_val;
  logic [ACC_LIMIT_W-1:0]   mse64;
  logic                     mse_hi;
  logic                     ratio_hi;

  assign in_ready_w  = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ready_w;
  assign in_ch.ready = in_ready_w;

  // difference, magnitudes and the one multiplier
  always_comb begin
    diff_s     = {tgt_r[SAMPLE_BITS-1], tgt_r} - {pred_r[SAMPLE_BITS-1], pred_r};
    diff_abs   = diff_s[SAMPLE_BITS] ? -diff_s : diff_s;
    tgt_abs    = tgt_r[SAMPLE_BITS-1] ? -{tgt_r[SAMPLE_BITS-1], tgt_r}
                                      : {tgt_r[SAMPLE_BITS-1], tgt_r};
    mul_op     = (state_r == ST_MUL_DIFF) ? diff_abs[SAMPLE_BITS-1:0]
                                          : tgt_abs[SAMPLE_BITS-1:0];
    prod_nxt   = PROD_W'(mul_op) * PROD_W'(mul_op);
    sq_sum_ext = {1'b0, sq_sum_r} + (SQ_W + 1)'(prod_r);
    sq_sum_nxt = sq_sum_ext[SQ_W] ? '1 : sq_sum_ext[SQ_W-1:0];
    te_ext     = {1'b0, te_r} + (TE_W + 1)'(prod_r);
    te_nxt     = te_ext[TE_W] ? '1 : te_ext[TE_W-1:0];
  end

  // quotient post-processing
  always_comb begin
    sum_neg    = diff_sum_r[DIFF_W-1];
    sum_abs    = sum_neg ? -diff_sum_r : diff_sum_r;
    mean_abs64 = ACC_LIMIT_W'(csu_quo[MAG_W-1:0]);
    mean_mag   = (mean_abs64 > ACC_LIMIT_W'(MEAN_MAG_MAX)) ? MEAN_MAG_MAX
                                                           : mean_abs64[MEAN_MAG_W-1:0];
    mean_val   = sum_neg ? -MEAN_W'(mean_mag) : MEAN_W'(mean_mag);
    mse64      = ACC_LIMIT_W'(csu_quo[SQ_W-1:0]);
    mse_hi     = |mse64[ACC_LIMIT_W-1:MSE_W];
    ratio_hi   = |csu_quo[NUM_W-1:RATIO_W];
  end

  // sequencer: next state and shared unit requests
  always_comb begin
    state_nxt = state_r;
    csu_ctrl  = '{start: 1'b0, mode: CSU_DIV, steps: '0};
    csu_num   = '0;
    csu_den   = '0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) state_nxt = ST_MUL_DIFF;
      end
      ST_MUL_DIFF: state_nxt = ST_MUL_TGT;
      ST_MUL_TGT:  state_nxt = ST_ACC_TGT;
      ST_ACC_TGT:  state_nxt = last_r ? ST_MEAN : ST_IDLE;
      ST_MEAN: begin
        if (cnt_r == '0) begin
          state_nxt = ST_RATIO;
        end else begin
          csu_ctrl  = '{start: 1'b1, mode: CSU_DIV, steps: STEP_W'(MAG_W)};
          csu_num   = NUM_W'(sum_abs[MAG_W-1:0]) << (NUM_W - MAG_W);
          csu_den   = DEN_W'(cnt_r);
          state_nxt = ST_MEAN_WAIT;
        end
      end
      ST_MEAN_WAIT: begin
        if (csu_done) begin
          csu_ctrl  = '{start: 1'b1, mode: CSU_DIV, steps: STEP_W'(SQ_W)};
          csu_num   = NUM_W'(sq_sum_r) << FRAC_W;
          csu_den   = DEN_W'(cnt_r);
          state_nxt = ST_MSE_WAIT;
        end
      end
      ST_MSE_WAIT: begin
        if (csu_done) begin
          if (mse_hi) begin
            state_nxt = ST_RATIO;
          end else begin
            csu_ctrl  = '{start: 1'b1, mode: CSU_SQRT, steps: STEP_W'(MSE_W / 2)};
            csu_num   = NUM_W'(mse64[MSE_W-1:0]) << (NUM_W - MSE_W);
            state_nxt = ST_ROOT_WAIT;
          end
        end
      end
      ST_ROOT_WAIT: begin
        if (csu_done) state_nxt = ST_RATIO;
      end
      ST_RATIO: begin
        if (te_r == '0) begin
          state_nxt = ST_OUT;
        end else begin
          csu_ctrl  = '{start: 1'b1, mode: CSU_DIV, steps: STEP_W'(NUM_W)};
          csu_num   = NUM_W'(sq_sum_r) << FRAC_W;
          csu_den   = te_r;
          state_nxt = ST_RATIO_WAIT;
        end
      end
      ST_RATIO_WAIT: begin
        if (csu_done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state, accumulators and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      diff_sum_r  <= '0;
      sq_sum_r    <= '0;
      te_r        <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // output valid: set on load, cleared on transfer
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_MUL_DIFF: begin
          if (take_r) begin
            cnt_r      <= cnt_r + CNT_W'(1);
            diff_sum_r <= diff_sum_r + DIFF_W'(diff_s);
          end else begin
            ovf_r <= 1'b1;
          end
        end
        ST_MUL_TGT: begin
          if (take_r) sq_sum_r <= sq_sum_nxt;
        end
        ST_ACC_TGT: begin
          if (take_r) te_r <= te_nxt;
        end
        ST_OUT: begin
          if (out_load) begin
            cnt_r       <= '0;
            diff_sum_r  <= '0;
            sq_sum_r    <= '0;
            te_r        <= '0;
            ovf_r       <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // sample capture, product and result registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      tgt_r  <= in_ch.target_sample;
      pred_r <= in_ch.predicted_sample;
      last_r <= in_ch.last_sample;
      take_r <= (cnt_r < CNT_W'(MAX_SAMPLES));
    end
    if (state_r == ST_MUL_DIFF || state_r == ST_MUL_TGT) prod_r <= prod_nxt;
    case (state_r)
      ST_MEAN: begin
        if (cnt_r == '0) begin
          mean_r <= '0;
          mse_r  <= '0;
          rms_r  <= '0;
        end
      end
      ST_MEAN_WAIT: begin
        if (csu_done) mean_r <= mean_val;
      end
      ST_MSE_WAIT: begin
        if (csu_done) begin
          mse_r <= mse_hi ? '1 : mse64[MSE_W-1:0];
          if (mse_hi) rms_r <= '1;
        end
      end
      ST_ROOT_WAIT: begin
        if (csu_done) rms_r <= csu_quo[RMS_W-1:0];
      end
      ST_RATIO: begin
        inv_r <= (te_r == '0);
        if (te_r == '0) ratio_r <= '1;
      end
      ST_RATIO_WAIT: begin
        if (csu_done) ratio_r <= ratio_hi ? '1 : csu_quo[RATIO_W-1:0];
      end
      ST_OUT: begin
        if (out_load) begin
          o_mean_r  <= mean_r;
          o_mse_r   <= mse_r;
          o_rms_r   <= rms_r;
          o_ratio_r <= ratio_r;
          o_inv_r   <= inv_r;
          o_ovf_r   <= ovf_r;
        end
      end
      default: ;
    endcase
  end

  // shared divide / square root unit
  ema_csu #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_csu (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (csu_ctrl),
    .num   (csu_num),
    .den   (csu_den),
    .done  (csu_done),
    .quo   (csu_quo)
  );

  assign out_ch.valid         = out_valid_r;
  assign out_ch.mean_diff     = o_mean_r;
  assign out_ch.mean_sq_error = o_mse_r;
  assign out_ch.root_mean_sq  = o_rms_r;
  assign out_ch.energy_ratio  = o_ratio_r;
  assign out_ch.ratio_invalid = o_inv_r;
  assign out_ch.overflowed    = o_ovf_r;

endmodule

>>> design/ema_chk.sv
module ema_chk import ema_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [MEAN_W-1:0] out_mean_diff,
  input logic [MSE_W-1:0]         out_mean_sq_error,
  input logic [RMS_W-1:0]         out_root_mean_sq,
  input logic [RATIO_W-1:0]       out_energy_ratio,
  input logic                     out_ratio_invalid,
  input logic                     out_overflowed
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mean_diff) &&
      $stable(out_mean_sq_error) && $stable(out_root_mean_sq) &&
      $stable(out_energy_ratio) && $stable(out_ratio_invalid) && $stable(out_overflowed))
    else $error("result changed while stalled");

  // one sample at a time: busy right after a transfer
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after an input transfer");

  // zero target energy saturates the ratio
  a_invalid_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ratio_invalid |-> out_energy_ratio == '1)
    else $error("invalid ratio not saturated");

  // root squared never exceeds the mse
  a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (64'(out_root_mean_sq) * 64'(out_root_mean_sq)) <= 64'(out_mean_sq_error))
    else $error("root larger than square root of mse");

  // zero mse forces zero mean difference
  a_zero_mse_mean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mean_sq_error == '0 |-> out_mean_diff == '0)
    else $error("nonzero mean with zero mse");

endmodule

bind error_metric_accumulator ema_chk u_ema_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_mean_diff     (out_ch.mean_diff),
  .out_mean_sq_error (out_ch.mean_sq_error),
  .out_root_mean_sq  (out_ch.root_mean_sq),
  .out_energy_ratio  (out_ch.energy_ratio),
  .out_ratio_invalid (out_ch.ratio_invalid),
  .out_overflowed    (out_ch.overflowed)
);
